[design/lap8_pkg.sv]
// Shared types and constants of the eighth-order Laplacian stencil.
package lap8_pkg;

   // Stencil taps, symmetric about the center: outer, second, third, fourth, center.
   localparam logic signed [15:0] TAP_OUTER  = -16'sd9;
   localparam logic signed [15:0] TAP_SECOND = 16'sd128;
   localparam logic signed [15:0] TAP_THIRD  = -16'sd1008;
   localparam logic signed [15:0] TAP_FOURTH = 16'sd8064;
   localparam logic signed [15:0] TAP_CENTER = -16'sd14350;

   // Configuration register indexes.
   localparam logic [2:0] REG_GRID_WIDTH       = 3'd0;
   localparam logic [2:0] REG_GRID_HEIGHT      = 3'd1;
   localparam logic [2:0] REG_VERTICAL_SCALE   = 3'd2;
   localparam logic [2:0] REG_HORIZONTAL_SCALE = 3'd3;
   localparam logic [2:0] REG_SCALE_SHIFT      = 3'd4;

   // Entries of the queue between the stencil front and the scaling back end.
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = 3;

   typedef struct packed {
      logic [11:0] center_row;
      logic [9:0]  center_column;
      logic        last;
   } lap8_meta_type;

endpackage

[design/lap8_front.sv]
// Stencil front: position tracking, eight line-store banks and the two axis sums.
module lap8_front #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_start_of_grid,
   input  logic [10:0]                   grid_width,
   input  logic [12:0]                   grid_height,
   output logic [1:0]                    inflight,
   output logic                          out_valid,
   output logic signed [SAMPLE_BITS+15:0] out_vsum,
   output logic signed [SAMPLE_BITS+15:0] out_hsum,
   output lap8_pkg::lap8_meta_type       out_meta
);
   import lap8_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int SW    = SAMPLE_BITS;
   localparam int PW    = SAMPLE_BITS + 1;
   localparam int SUM_W = SAMPLE_BITS + 16;

   function automatic logic signed [SUM_W-1:0] stencil(
      input logic signed [PW-1:0] p0, input logic signed [PW-1:0] p1,
      input logic signed [PW-1:0] p2, input logic signed [PW-1:0] p3,
      input logic signed [SW-1:0] m);
      logic signed [SUM_W-1:0] acc;
      acc = SUM_W'(p0) * SUM_W'(TAP_OUTER) + SUM_W'(p1) * SUM_W'(TAP_SECOND)
          + SUM_W'(p2) * SUM_W'(TAP_THIRD) + SUM_W'(p3) * SUM_W'(TAP_FOURTH)
          + SUM_W'(m) * SUM_W'(TAP_CENTER);
      return acc;
   endfunction

   // Position and geometry.
   logic [CW-1:0] col_ff, col_in, col;
   logic [RW-1:0] row_ff, row_in, row;
   logic [CW:0]   w_use;
   logic [RW:0]   h_use;
   logic          row_end, grid_end, emit;
   logic [31:0]   crow_full, ccol_full;
   lap8_meta_type meta;

   always_comb begin
      if (grid_width < 11'd9) begin
         w_use = (CW+1)'(9);
      end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
         w_use = (CW+1)'(MAX_WIDTH);
      end else begin
         w_use = (CW+1)'(grid_width);
      end
      if (grid_height < 13'd9) begin
         h_use = (RW+1)'(9);
      end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
         h_use = (RW+1)'(MAX_HEIGHT);
      end else begin
         h_use = (RW+1)'(grid_height);
      end
      col      = req_start_of_grid ? '0 : col_ff;
      row      = req_start_of_grid ? '0 : row_ff;
      row_end  = {1'b0, col} >= (w_use - (CW+1)'(1));
      grid_end = row_end && ({1'b0, row} >= (h_use - (RW+1)'(1)));
      emit     = (row >= RW'(8)) && (col >= CW'(8));
      crow_full = 32'(row) - 32'd4;
      ccol_full = 32'(col) - 32'd4;
      meta.center_row    = crow_full[11:0];
      meta.center_column = ccol_full[9:0];
      meta.last          = grid_end;
      if (row_end) begin
         col_in = '0;
         row_in = grid_end ? '0 : row + RW'(1);
      end else begin
         col_in = col + CW'(1);
         row_in = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store: bank b holds the rows whose index is b modulo eight. The current
   // row overwrites the row eight above it; the read sees the older value.
   logic signed [SW-1:0] bank_rd_ff [8];

   for (genvar b = 0; b < 8; b++) begin : g_bank
      logic signed [SW-1:0] mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (accept && row[2:0] == 3'(b)) begin
            mem[col] <= req_sample;
         end
         if (accept) begin
            bank_rd_ff[b] <= mem[col];
         end
      end
   end

   // Stage one: line-store data is back.
   logic                 v1_ff, emit1_ff;
   logic signed [SW-1:0] sample1_ff;
   logic [2:0]           slot1_ff;
   lap8_meta_type        meta1_ff;
   logic signed [SW-1:0] rot [8];

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         rot[k] = bank_rd_ff[3'(slot1_ff + 3'(k))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      if (accept) begin
         sample1_ff <= req_sample;
         slot1_ff   <= row[2:0];
         emit1_ff   <= emit;
         meta1_ff   <= meta;
      end
   end

   // Stage two: vertical pairs of column c and the row window of row r-4.
   logic                 v2_ff, emit2_ff;
   lap8_meta_type        meta2_ff;
   logic signed [PW-1:0] vp_ff [4];
   logic signed [SW-1:0] vmid_ff;
   logic signed [SW-1:0] hwin_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      if (v1_ff) begin
         emit2_ff <= emit1_ff;
         meta2_ff <= meta1_ff;
         vp_ff[0] <= PW'(rot[0]) + PW'(sample1_ff);
         vp_ff[1] <= PW'(rot[1]) + PW'(rot[7]);
         vp_ff[2] <= PW'(rot[2]) + PW'(rot[6]);
         vp_ff[3] <= PW'(rot[3]) + PW'(rot[5]);
         vmid_ff  <= rot[4];
         for (int k = 0; k < 8; k++) begin
            hwin_ff[k] <= hwin_ff[k+1];
         end
         hwin_ff[8] <= rot[4];
      end
   end

   // Stage three: vertical sums wait four items so they line up with column c-4.
   logic                    v3_ff, emit3_ff;
   lap8_meta_type           meta3_ff;
   logic signed [SUM_W-1:0] vline_ff [5];
   logic signed [PW-1:0]    hp_ff [4];
   logic signed [SW-1:0]    hmid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      if (v2_ff) begin
         emit3_ff <= emit2_ff;
         meta3_ff <= meta2_ff;
         for (int k = 4; k > 0; k--) begin
            vline_ff[k] <= vline_ff[k-1];
         end
         vline_ff[0] <= stencil(vp_ff[0], vp_ff[1], vp_ff[2], vp_ff[3], vmid_ff);
         hp_ff[0] <= PW'(hwin_ff[0]) + PW'(hwin_ff[8]);
         hp_ff[1] <= PW'(hwin_ff[1]) + PW'(hwin_ff[7]);
         hp_ff[2] <= PW'(hwin_ff[2]) + PW'(hwin_ff[6]);
         hp_ff[3] <= PW'(hwin_ff[3]) + PW'(hwin_ff[5]);
         hmid_ff  <= hwin_ff[4];
      end
   end

   assign out_valid = v3_ff && emit3_ff;
   assign out_vsum  = vline_ff[4];
   assign out_hsum  = stencil(hp_ff[0], hp_ff[1], hp_ff[2], hp_ff[3], hmid_ff);
   assign out_meta  = meta3_ff;
   assign inflight  = {1'b0, v1_ff} + {1'b0, v2_ff} + {1'b0, v3_ff};

endmodule

[design/lap8_queue.sv]
// Small first-in first-out queue between the stencil front and the back end.
module lap8_queue #(
   parameter int DATA_W = 103
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              q_valid,
   output logic [DATA_W-1:0] q_data,
   output logic [lap8_pkg::QUEUE_PTR_W:0] q_count
);
   import lap8_pkg::*;

   logic [DATA_W-1:0]      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, rd_ff;
   logic [QUEUE_PTR_W:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
      end
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   assign q_valid = count_ff != '0;
   assign q_data  = entry_ff[rd_ff];
   assign q_count = count_ff;

endmodule

[design/lap8_back.sv]
// Back end: scale both axis sums, add, shift, saturate and hold the result item.
module lap8_back #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  logic signed [SAMPLE_BITS+15:0] q_vsum,
   input  logic signed [SAMPLE_BITS+15:0] q_hsum,
   input  lap8_pkg::lap8_meta_type        q_meta,
   input  logic [31:0]                    vertical_scale,
   input  logic [31:0]                    horizontal_scale,
   input  logic [5:0]                     scale_shift,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [31:0]             rsp_laplacian,
   output logic [11:0]                    rsp_center_row,
   output logic [9:0]                     rsp_center_column,
   output logic                           rsp_last
);
   import lap8_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + 16;
   localparam int PROD_W = SUM_W + 17;
   localparam int TW     = SUM_W + 33;

   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign pop = adv && q_valid;

   // Stage one: four half-width products.
   logic                     b1_v_ff;
   lap8_meta_type            b1_meta_ff;
   logic signed [PROD_W-1:0] vl_ff, vh_ff, hl_ff, hh_ff;
   // Stage two: per-axis scaled sums.
   logic                     b2_v_ff;
   lap8_meta_type            b2_meta_ff;
   logic signed [TW-1:0]     pv_ff, ph_ff;
   // Stage three: exact total.
   logic                     b3_v_ff;
   lap8_meta_type            b3_meta_ff;
   logic signed [TW-1:0]     tot_ff;
   // Stage four: result register.
   logic                     b4_v_ff;
   lap8_meta_type            b4_meta_ff;
   logic signed [31:0]       lap_ff;

   logic signed [TW-1:0] shifted;
   logic signed [31:0]   sat;

   always_comb begin
      shifted = tot_ff >>> scale_shift;
      if (shifted[TW-1:31] == '0 || shifted[TW-1:31] == '1) begin
         sat = shifted[31:0];
      end else if (shifted[TW-1]) begin
         sat = 32'sh8000_0000;
      end else begin
         sat = 32'sh7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
         b4_v_ff <= 1'b0;
      end else if (adv) begin
         b1_v_ff <= pop;
         b2_v_ff <= b1_v_ff;
         b3_v_ff <= b2_v_ff;
         b4_v_ff <= b3_v_ff;
      end
      if (adv) begin
         b1_meta_ff <= q_meta;
         vl_ff <= PROD_W'(q_vsum) * PROD_W'($signed({1'b0, vertical_scale[15:0]}));
         vh_ff <= PROD_W'(q_vsum) * PROD_W'($signed({1'b0, vertical_scale[31:16]}));
         hl_ff <= PROD_W'(q_hsum) * PROD_W'($signed({1'b0, horizontal_scale[15:0]}));
         hh_ff <= PROD_W'(q_hsum) * PROD_W'($signed({1'b0, horizontal_scale[31:16]}));
         b2_meta_ff <= b1_meta_ff;
         pv_ff <= TW'(vl_ff) + (TW'(vh_ff) <<< 16);
         ph_ff <= TW'(hl_ff) + (TW'(hh_ff) <<< 16);
         b3_meta_ff <= b2_meta_ff;
         tot_ff <= pv_ff + ph_ff;
         b4_meta_ff <= b3_meta_ff;
         lap_ff <= sat;
      end
   end

   assign rsp_valid         = b4_v_ff;
   assign rsp_laplacian     = lap_ff;
   assign rsp_center_row    = b4_meta_ff.center_row;
   assign rsp_center_column = b4_meta_ff.center_column;
   assign rsp_last          = b4_meta_ff.last;

endmodule

[design/laplacian_stencil_8th_order_2d.sv]
// Top level of the streaming eighth-order 2-D Laplacian stencil.
//
// Samples enter in raster order on the req_ channel (valid/ready); start_of_grid
// marks the first sample of a grid and returns the position to row 0, column 0.
// Once sample (r,c) with r >= 8 and c >= 8 is taken, one item leaves on the rsp_
// channel carrying the Laplacian of center point (r-4,c-4); border points give none.
// The csr_ channel writes the geometry, the two axis scales and the final shift,
// and must only be used while the block is idle.
// From the accepting edge to rsp_valid an item passes three front stages
// (line-store read, pair sums, tap sums), the queue and three more back
// stages after the pop (axis sums, total, shift and saturate into the result).
// Throughput is one sample per cycle: the front holds at most three items in
// flight and takes a sample whenever those plus the queued items stay below
// the eight queue entries.
// When the receiver stalls, the back end holds its result, the queue fills and
// req_ready falls; nothing is dropped. Reset clears position, queue and valids;
// the line store is not cleared, and each row is rewritten before it is read.
module laplacian_stencil_8th_order_2d #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_start_of_grid,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_laplacian,
   output logic [11:0]                   rsp_center_row,
   output logic [9:0]                    rsp_center_column,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_data
);
   import lap8_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + 16;
   localparam int META_W = $bits(lap8_meta_type);
   localparam int DATA_W = 2 * SUM_W + META_W;

   // Configuration registers.
   logic [10:0] grid_width_ff;
   logic [12:0] grid_height_ff;
   logic [31:0] vertical_scale_ff, horizontal_scale_ff;
   logic [5:0]  scale_shift_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff       <= 11'd1024;
         grid_height_ff      <= 13'd4096;
         vertical_scale_ff   <= 32'd1;
         horizontal_scale_ff <= 32'd1;
         scale_shift_ff      <= 6'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GRID_WIDTH:       grid_width_ff       <= csr_data[10:0];
            REG_GRID_HEIGHT:      grid_height_ff      <= csr_data[12:0];
            REG_VERTICAL_SCALE:   vertical_scale_ff   <= csr_data;
            REG_HORIZONTAL_SCALE: horizontal_scale_ff <= csr_data;
            REG_SCALE_SHIFT:      scale_shift_ff      <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Credit check: every item in the front may still need a queue entry.
   logic [1:0]             inflight;
   logic [QUEUE_PTR_W:0]   q_count;
   logic                   accept;

   assign req_ready = ({1'b0, q_count} + (QUEUE_PTR_W+2)'(inflight))
                      < (QUEUE_PTR_W+2)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   logic                    f_valid;
   logic signed [SUM_W-1:0] f_vsum, f_hsum;
   lap8_meta_type           f_meta;

   lap8_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_sample        (req_sample),
      .req_start_of_grid (req_start_of_grid),
      .grid_width        (grid_width_ff),
      .grid_height       (grid_height_ff),
      .inflight          (inflight),
      .out_valid         (f_valid),
      .out_vsum          (f_vsum),
      .out_hsum          (f_hsum),
      .out_meta          (f_meta)
   );

   logic              q_valid, q_pop;
   logic [DATA_W-1:0] q_data;

   lap8_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data ({f_vsum, f_hsum, f_meta}),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_count   (q_count)
   );

   lap8_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_vsum            ($signed(q_data[DATA_W-1 -: SUM_W])),
      .q_hsum            ($signed(q_data[META_W +: SUM_W])),
      .q_meta            (lap8_meta_type'(q_data[META_W-1:0])),
      .vertical_scale    (vertical_scale_ff),
      .horizontal_scale  (horizontal_scale_ff),
      .scale_shift       (scale_shift_ff),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_laplacian     (rsp_laplacian),
      .rsp_center_row    (rsp_center_row),
      .rsp_center_column (rsp_center_column),
      .rsp_last          (rsp_last)
   );

   // The credit scheme must never let queued plus in-flight items exceed the queue.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, q_count} + (QUEUE_PTR_W+2)'(inflight)) <= (QUEUE_PTR_W+2)'(QUEUE_DEPTH))
      else $error("queue credit exceeded");

   // A result from the front never arrives at a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      f_valid |-> (q_count < (QUEUE_PTR_W+1)'(QUEUE_DEPTH)))
      else $error("push into full queue");

   // Reset leaves the queue empty and no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && q_count == '0 && inflight == 2'd0))
      else $error("state left over after reset");

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the streaming eighth-order 2-D Laplacian stencil.
//
// Grids are streamed in raster order on the req_ channel.  A scoreboard object
// keeps its own copy of the line store, the row window, the grid position and
// the configuration registers.  For every accepted sample it works out the
// Laplacian item that the block owes, if any, and queues it.  Every item taken
// from the rsp_ channel is compared field by field with the oldest queued one.
//
// The run starts with a directed part: clamped geometry, full-range scales with
// extreme samples to force saturation, a clamped width, an interrupted grid,
// wrap into a new grid without start_of_grid under the largest shift, and a
// clamped height.  Random grids with random scales and shifts follow.  Sender and
// receiver idle at random; once the receiver holds off for a long stretch so that
// the block fills up and stalls its input.
module tb_top;
   import lap8_pkg::*;

   // One Laplacian item as the block should deliver it.
   typedef struct {
      logic signed [31:0] laplacian;
      logic [11:0]        center_row;
      logic [9:0]         center_column;
      logic               last;
   } lap_item_type;

   // Sample patterns used to fill a grid.
   typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SMALL} fill_kind_type;

   // Scoreboard: predicts the stencil output and checks what comes back.
   class stencil_scoreboard;
      localparam logic signed [127:0] LAP_MAX = 128'sh7FFF_FFFF;
      localparam logic signed [127:0] LAP_MIN = -128'sh8000_0000;

      logic [23:0]   line_rows [8][1024];
      logic [23:0]   row_tail [9];
      int unsigned   row_pos;
      int unsigned   col_pos;
      logic [10:0]   grid_width;
      logic [12:0]   grid_height;
      logic [31:0]   vertical_scale;
      logic [31:0]   horizontal_scale;
      logic [5:0]    scale_shift;
      longint        taps [9];
      lap_item_type  owed [$];
      int            errors;

      function new();
         taps = '{TAP_OUTER, TAP_SECOND, TAP_THIRD, TAP_FOURTH, TAP_CENTER,
                  TAP_FOURTH, TAP_THIRD, TAP_SECOND, TAP_OUTER};
         grid_width = 11'd1024;
         grid_height = 13'd4096;
         vertical_scale = 32'd1;
         horizontal_scale = 32'd1;
         scale_shift = 6'd0;
         row_pos = 0;
         col_pos = 0;
         errors = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [31:0] data);
         case (index)
            REG_GRID_WIDTH:       grid_width = data[10:0];
            REG_GRID_HEIGHT:      grid_height = data[12:0];
            REG_VERTICAL_SCALE:   vertical_scale = data;
            REG_HORIZONTAL_SCALE: horizontal_scale = data;
            REG_SCALE_SHIFT:      scale_shift = data[5:0];
            default: ;
         endcase
      endfunction

      // Advances the position by one accepted sample and queues the item it causes.
      function void note_sample(logic [23:0] sample, logic start_of_grid);
         int unsigned w, h, r, c;
         bit row_end, grid_end;
         longint vsum, hsum;
         logic signed [127:0] vsum_w, hsum_w, total;
         lap_item_type item;

         w = (grid_width < 9) ? 9 : (grid_width > 1024) ? 1024 : grid_width;
         h = (grid_height < 9) ? 9 : (grid_height > 4096) ? 4096 : grid_height;
         if (start_of_grid) begin
            row_pos = 0;
            col_pos = 0;
         end
         r = row_pos;
         c = col_pos;
         row_end = (c >= w - 1);
         grid_end = row_end && (r >= h - 1);

         for (int k = 0; k < 8; k++)
            row_tail[k] = row_tail[k + 1];
         row_tail[8] = sample;

         if (r >= 8 && c >= 8) begin
            vsum = 0;
            hsum = 0;
            for (int k = 0; k < 8; k++)
               vsum += taps[k] * longint'($signed(line_rows[(r - 8 + k) % 8][c - 4]));
            vsum += taps[8] * longint'($signed(row_tail[4]));
            for (int k = 0; k < 9; k++)
               hsum += taps[k] * longint'($signed(line_rows[(r - 4) % 8][c - 8 + k]));
            vsum_w = vsum;
            hsum_w = hsum;
            total = vsum_w * $signed({96'd0, vertical_scale})
                  + hsum_w * $signed({96'd0, horizontal_scale});
            total = total >>> scale_shift;
            if (total > LAP_MAX)
               item.laplacian = 32'sh7FFF_FFFF;
            else if (total < LAP_MIN)
               item.laplacian = 32'sh8000_0000;
            else
               item.laplacian = total[31:0];
            item.center_row = 12'(r - 4);
            item.center_column = 10'(c - 4);
            item.last = grid_end;
            owed.push_back(item);
         end

         // The current row reaches the line store four columns late; the tail
         // is flushed at the end of the row.
         if (c >= 4)
            line_rows[r % 8][(c - 4) % 1024] = row_tail[4];
         if (row_end && c >= 8)
            for (int k = 5; k < 9; k++)
               line_rows[r % 8][(c - 8 + k) % 1024] = row_tail[k];

         if (row_end) begin
            col_pos = 0;
            row_pos = grid_end ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
      endfunction

      function void check_result(logic signed [31:0] laplacian, logic [11:0] center_row,
                                 logic [9:0] center_column, logic last);
         lap_item_type item;
         if (owed.size() == 0) begin
            $display("%0t: unexpected item lap=%0d row=%0d col=%0d last=%0b", $time,
                     laplacian, center_row, center_column, last);
            errors++;
            return;
         end
         item = owed.pop_front();
         if (laplacian !== item.laplacian) begin
            $display("%0t: laplacian expected %0d actual %0d", $time, item.laplacian,
                     laplacian);
            errors++;
         end
         if (center_row !== item.center_row) begin
            $display("%0t: center_row expected %0d actual %0d", $time, item.center_row,
                     center_row);
            errors++;
         end
         if (center_column !== item.center_column) begin
            $display("%0t: center_column expected %0d actual %0d", $time,
                     item.center_column, center_column);
            errors++;
         end
         if (last !== item.last) begin
            $display("%0t: last expected %0b actual %0b", $time, item.last, last);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [23:0] req_sample;
   logic               req_start_of_grid;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_laplacian;
   logic [11:0]        rsp_center_row;
   logic [9:0]         rsp_center_column;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   stencil_scoreboard  board;
   int                 sender_idle_pct;
   int                 receiver_idle_pct;
   logic               hold_request;
   int                 hold_left;
   int                 quiet_cycles;

   laplacian_stencil_8th_order_2d uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_start_of_grid (req_start_of_grid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_laplacian     (rsp_laplacian),
      .rsp_center_row    (rsp_center_row),
      .rsp_center_column (rsp_center_column),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Handshakes are sampled at the edge, before any nonblocking update lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.write_register(csr_index, csr_data);
         if (req_valid && req_ready)
            board.note_sample(req_sample, req_start_of_grid);
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_laplacian, rsp_center_row, rsp_center_column, rsp_last);
      end
   end

   // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
   always @(posedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = 400;
         hold_request <= 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Watchdog: ends the run when no handshake happens for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= 5000) begin
         $display("laplacian_stencil_8th_order_2d verification failed");
         $finish;
      end
   end

   // Offers one sample and returns at the edge where it is taken; valid stays high.
   task automatic send_sample(logic [23:0] sample, logic start_of_grid);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= sample;
      req_start_of_grid <= start_of_grid;
      do @(posedge clock); while (!req_ready);
   endtask

   // Streams `rows` rows of a w-column grid; the first sample may skip start_of_grid.
   task automatic send_grid(int w, int rows, fill_kind_type fill, bit mark_start);
      logic [23:0] sample;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < w; c++) begin
            case (fill)
               FILL_EXTREME: sample = $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
               FILL_SMALL:   sample = 24'($signed($urandom_range(64)) - 32);
               default:      sample = 24'($urandom);
            endcase
            send_sample(sample, mark_start && r == 0 && c == 0);
         end
      end
   endtask

   // Lets every owed item arrive, then waits out samples still in flight.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.owed.size() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(logic [31:0] w, logic [31:0] h, logic [31:0] vscale,
                            logic [31:0] hscale, logic [31:0] shift);
      wait_drained();
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_HEIGHT, h);
      write_reg(REG_VERTICAL_SCALE, vscale);
      write_reg(REG_HORIZONTAL_SCALE, hscale);
      write_reg(REG_SCALE_SHIFT, shift);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int w;
      int h;
      board = new();
      sender_idle_pct = 29;
      receiver_idle_pct = 49;
      hold_request = 1'b0;
      hold_left = 0;
      quiet_cycles = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample <= '0;
      req_start_of_grid <= 1'b0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= REG_GRID_WIDTH;
      csr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Geometry below the minimum clamps to 9x9; full scales with extreme
      // samples drive the sum far past 32 bits, so the result saturates.
      configure(0, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_grid(9, 9, FILL_EXTREME, 1);

      // A width beyond the maximum clamps to 1024 columns, so twenty samples
      // stay inside the first row; the next grid restarts the position.
      configure(11'h7FF, 9, $urandom, $urandom, $urandom_range(24, 40));
      send_grid(20, 1, FILL_RANDOM, 1);

      // Zero horizontal scale leaves the vertical sum alone. A new start_of_grid
      // after three rows restarts at row 0.
      configure(9, 9, 32'h8000_0000, 0, 20);
      send_grid(9, 3, FILL_RANDOM, 1);
      send_grid(9, 9, FILL_RANDOM, 1);

      // After the last sample the position wraps to the next grid by itself;
      // the largest shift keeps only the bits of the total above bit 62.
      configure(9, 9, 32'd1, 32'hFFFF_FFFF, 63);
      send_grid(9, 9, FILL_EXTREME, 0);

      // Height above the maximum clamps to 4096; the grid is cut short, and
      // the receiver holds off meanwhile so the block backs up its input.
      configure(12, 13'h1FFF, $urandom, $urandom, 32);
      hold_request <= 1'b1;
      send_grid(12, 12, FILL_RANDOM, 1);

      // Random grids: first the sender idles more than the receiver, then
      // neither side idles.
      for (int phase = 0; phase < 2; phase++) begin
         sender_idle_pct = (phase == 0) ? 49 : 0;
         receiver_idle_pct = (phase == 0) ? 29 : 0;
         w = $urandom_range(9, 10);
         h = $urandom_range(9, 10);
         configure(w, h, $urandom_range(1) ? $urandom : $urandom_range(4096),
                   $urandom_range(1) ? $urandom : $urandom_range(4096),
                   $urandom_range(63));
         send_grid(w, h, fill_kind_type'($urandom_range(2)), 1);
      end

      wait_drained();
      if (board.errors == 0)
         $display("laplacian_stencil_8th_order_2d verification clean");
      else
         $display("laplacian_stencil_8th_order_2d verification failed");
      $finish;
   end

endmodule
